[src/integral_image_box_mean_filter_macros.svh]
// Assertion macros for the integral image box mean filter.
// Depends on nothing; included by the top level.
`ifndef INTEGRAL_IMAGE_BOX_MEAN_FILTER_MACROS_SVH
`define INTEGRAL_IMAGE_BOX_MEAN_FILTER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IIBM_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define IIBM_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define IIBM_ASSERT_IMPL(label, clk, rst, prop)
`define IIBM_ASSERT_NORST(label, clk, prop)
`endif
`endif

[src/iibm_pkg.sv]
// Shared constants and types for the integral image box mean filter.
// No dependencies.
package iibm_pkg;
  localparam int MaxCols = 512;
  localparam int MaxRows = 512;
  localparam int Channels = 3;
  localparam int ColW = $clog2(MaxCols);
  localparam int RowW = $clog2(MaxRows);
  localparam int SizeW = 10;
  localparam int RadW = 9;
  localparam int EntryW = 27;
  localparam int AddrW = ColW + RowW;
  localparam int AreaW = 2 * SizeW;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegRadius = 2'd2;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef logic [EntryW-1:0] entry_t;
  typedef logic [Channels*EntryW-1:0] pix_t;

  typedef struct packed {
    logic              start;
    logic [EntryW-1:0] dividend;
    logic [AreaW-1:0]  divisor;
  } div_req_t;
endpackage

[src/iibm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module iibm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/iibm_lane.sv]
// One channel lane: a restoring divider of a window sum by the window area.
// Depends on iibm_pkg.
module iibm_lane (
  input  logic                      clk,
  input  logic                      rst,
  input  iibm_pkg::div_req_t        req,
  output logic                      done,
  output logic [7:0]                quotient
);
  import iibm_pkg::*;

  logic [EntryW-1:0] rem;
  logic [EntryW-1:0] quo;
  logic [AreaW-1:0]  dvs;
  logic [4:0]        cnt;
  logic              busy;
  logic [EntryW:0]   trial;

  // one quotient bit per cycle
  always_comb begin
    trial = {rem[EntryW-2:0], quo[EntryW-1]} - {{(EntryW+1-AreaW){1'b0}}, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
        cnt  <= 5'(EntryW - 1);
      end else if (busy) begin
        if (!trial[EntryW]) begin
          rem <= trial[EntryW-1:0];
          quo <= {quo[EntryW-2:0], 1'b1};
        end else begin
          rem <= {rem[EntryW-2:0], quo[EntryW-1]};
          quo <= {quo[EntryW-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 5'd1;
      end
    end
  end

  assign quotient = quo[7:0];
endmodule

[src/integral_image_box_mean_filter.sv]
// Box mean filter on a three-channel integral image held in one RAM.
// Load: left, up and up-left reads, then the write of the new entry.
// Query: 4 corner reads, then a restoring divider in three parallel lanes. A new item
// is accepted only in IDLE, after the previous result has been taken.
// Reset (rst, synchronous) clears control state and the load position; table contents
// are undefined until loaded.
`include "integral_image_box_mean_filter_macros.svh"
module integral_image_box_mean_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] red_in, [15:8] green_in, [23:16] blue_in,
  // [32:24] query_row, [41:33] query_col, [47:42] zero
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] mean_red, [15:8] mean_green, [23:16] mean_blue
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import iibm_pkg::*;

  typedef enum logic [3:0] {
    IDLE, LRD, LWAIT, LWR, QRD, QSUM, QDIV, QOUT
  } state_t;

  state_t state;
  logic [SizeW-1:0] image_width, image_height;
  logic [RadW-1:0]  radius;
  logic [RowW-1:0]  load_row;
  logic [ColW-1:0]  load_col;

  // latched item
  logic [7:0] px [Channels];
  logic [RowW-1:0] cr;
  logic [ColW-1:0] cc;
  // query window bounds (stored +1 where needed)
  logic [RowW:0] r0, r1p;
  logic [ColW:0] c0, c1p;
  logic [AreaW-1:0] area;

  logic [2:0] step;
  logic [RowW:0] rd_r;
  logic [ColW:0] rd_c;
  logic rd_zero, zero_q;
  logic [1:0] tap_q;
  logic rd_live;
  entry_t acc [Channels];
  entry_t rd_val [Channels];

  logic ram_we;
  logic [AddrW-1:0] ram_raddr;
  pix_t ram_wdata, ram_rdata;

  iibm_ram #(.Width(Channels*EntryW), .Depth(MaxRows*MaxCols)) u_ram (
    .clk(clk), .we(ram_we), .waddr({cr, cc}), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // effective size
  logic [SizeW-1:0] w_eff, h_eff;
  always_comb begin
    w_eff = (image_width == '0) ? SizeW'(1)
          : (image_width > SizeW'(MaxCols)) ? SizeW'(MaxCols) : image_width;
    h_eff = (image_height == '0) ? SizeW'(1)
          : (image_height > SizeW'(MaxRows)) ? SizeW'(MaxRows) : image_height;
  end

  // load position with shrink wrap applied
  logic [RowW-1:0] lr_eff;
  logic [ColW-1:0] lc_eff;
  always_comb begin
    logic [SizeW:0] tr;
    tr = {1'b0, SizeW'(load_row)};
    lc_eff = load_col;
    if (SizeW'(load_col) >= w_eff) begin
      lc_eff = '0;
      tr = tr + 1'b1;
    end
    if (tr >= {1'b0, h_eff}) begin
      tr = '0;
      lc_eff = '0;
    end
    lr_eff = tr[RowW-1:0];
  end

  // query bounds
  logic [SizeW-1:0] qr_s, qc_s;
  logic [SizeW:0] qr_hi, qc_hi;
  always_comb begin
    qr_s = (SizeW'(s_axis_tdata[32:24]) > h_eff - 1'b1) ? h_eff - 1'b1
           : SizeW'(s_axis_tdata[32:24]);
    qc_s = (SizeW'(s_axis_tdata[41:33]) > w_eff - 1'b1) ? w_eff - 1'b1
           : SizeW'(s_axis_tdata[41:33]);
    qr_hi = {1'b0, qr_s} + (SizeW+1)'(radius);
    qc_hi = {1'b0, qc_s} + (SizeW+1)'(radius);
  end

  // corner read address: step selects tap
  always_comb begin
    rd_r = '0; rd_c = '0;
    if (state == LRD) begin
      case (step[1:0])
        2'd0:    begin rd_r = {1'b0, cr} + 1'b1; rd_c = {1'b0, cc}; end
        2'd1:    begin rd_r = {1'b0, cr}; rd_c = {1'b0, cc} + 1'b1; end
        default: begin rd_r = {1'b0, cr}; rd_c = {1'b0, cc}; end
      endcase
    end else begin
      case (step[1:0])
        2'd0:    begin rd_r = r1p; rd_c = c1p; end
        2'd1:    begin rd_r = r1p; rd_c = c0; end
        2'd2:    begin rd_r = r0;  rd_c = c1p; end
        default: begin rd_r = r0;  rd_c = c0; end
      endcase
    end
    rd_zero = (rd_r == '0) || (rd_c == '0);
    ram_raddr = {RowW'(rd_r - 1'b1), ColW'(rd_c - 1'b1)};
  end

  // read data, border taps forced to zero
  always_comb begin
    for (int k = 0; k < Channels; k++) begin
      rd_val[k] = zero_q ? '0 : ram_rdata[k*EntryW +: EntryW];
    end
  end

  always_comb begin
    for (int k = 0; k < Channels; k++) begin
      ram_wdata[k*EntryW +: EntryW] = acc[k] + EntryW'(px[k]);
    end
  end

  div_req_t req [Channels];
  logic [Channels-1:0] ldone;
  logic [7:0] quo [Channels];
  logic [Channels-1:0] got;
  logic [7:0] res [Channels];

  for (genvar k = 0; k < Channels; k++) begin : g_lane
    iibm_lane u_lane (
      .clk(clk), .rst(rst), .req(req[k]), .done(ldone[k]), .quotient(quo[k])
    );
    always_comb begin
      req[k].start = (state == QSUM) && !rd_live;
      req[k].dividend = acc[k];
      req[k].divisor = area;
    end
  end

  assign s_axis_tready = (state == IDLE);
  assign cfg_ready = (state == IDLE);
  assign ram_we = (state == LWR);
  assign m_axis_tvalid = (state == QOUT);
  assign m_axis_tdata = {res[0], res[1], res[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      image_width <= 10'd512;
      image_height <= 10'd512;
      radius <= 9'd1;
      load_row <= '0;
      load_col <= '0;
      step <= '0;
      rd_live <= 1'b0;
      got <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegWidth:  image_width <= cfg_data;
          RegHeight: image_height <= cfg_data;
          RegRadius: radius <= cfg_data[RadW-1:0];
          default:   ;
        endcase
      end
      // data from a read issued last cycle
      if (rd_live) begin
        for (int k = 0; k < Channels; k++) begin
          if (state == LRD || state == LWAIT) begin
            acc[k] <= (tap_q == 2'd2) ? acc[k] - rd_val[k] : acc[k] + rd_val[k];
          end else begin
            acc[k] <= (tap_q == 2'd1 || tap_q == 2'd2) ? acc[k] - rd_val[k]
                      : acc[k] + rd_val[k];
          end
        end
      end
      zero_q <= rd_zero;
      tap_q <= step[1:0];
      case (state)
        IDLE: begin
          rd_live <= 1'b0;
          if (s_axis_tvalid) begin
            for (int k = 0; k < Channels; k++) acc[k] <= '0;
            step <= '0;
            if (s_axis_tuser == OpLoad) begin
              px[0] <= s_axis_tdata[23:16];
              px[1] <= s_axis_tdata[15:8];
              px[2] <= s_axis_tdata[7:0];
              cr <= lr_eff;
              cc <= lc_eff;
              state <= LRD;
            end else begin
              r0 <= ((RowW+1)'(qr_s) > (RowW+1)'(radius))
                    ? (RowW+1)'(qr_s) - (RowW+1)'(radius) : '0;
              c0 <= ((ColW+1)'(qc_s) > (ColW+1)'(radius))
                    ? (ColW+1)'(qc_s) - (ColW+1)'(radius) : '0;
              r1p <= (qr_hi > {1'b0, h_eff - 1'b1}) ? (RowW+1)'(h_eff)
                     : (RowW+1)'(qr_hi + 1'b1);
              c1p <= (qc_hi > {1'b0, w_eff - 1'b1}) ? (ColW+1)'(w_eff)
                     : (ColW+1)'(qc_hi + 1'b1);
              state <= QRD;
            end
          end
        end
        LRD: begin
          rd_live <= 1'b1;
          step <= step + 3'd1;
          if (step == 3'd2) state <= LWAIT;
        end
        LWAIT: begin
          rd_live <= 1'b0;
          state <= LWR;
        end
        LWR: begin
          if (SizeW'(cc) + 1'b1 >= w_eff) begin
            load_col <= '0;
            load_row <= (SizeW'(cr) + 1'b1 >= h_eff) ? '0 : cr + 1'b1;
          end else begin
            load_col <= cc + 1'b1;
            load_row <= cr;
          end
          state <= IDLE;
        end
        QRD: begin
          rd_live <= 1'b1;
          step <= step + 3'd1;
          area <= AreaW'(r1p - r0) * AreaW'(c1p - c0);
          if (step == 3'd3) state <= QSUM;
        end
        QSUM: begin
          rd_live <= 1'b0;
          got <= '0;
          if (!rd_live) state <= QDIV;
        end
        QDIV: begin
          for (int k = 0; k < Channels; k++) begin
            if (ldone[k]) res[k] <= quo[k];
          end
          got <= got | ldone;
          if ((got | ldone) == '1) state <= QOUT;
        end
        QOUT: begin
          if (m_axis_tready) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  `IIBM_ASSERT_IMPL(a_out_only_qout, clk, rst, m_axis_tvalid |-> !s_axis_tready)
  `IIBM_ASSERT_IMPL(a_no_write_in_query, clk, rst, ram_we |-> !m_axis_tvalid)
  `IIBM_ASSERT_IMPL(a_out_after_div, clk, rst, $rose(m_axis_tvalid) |-> $past(state == QDIV))
endmodule
